>>> hw/rtl/closest_point_on_rectangle_defines.svh
// Assertion macros for the closest point on rectangle block
`ifndef CLOSEST_POINT_ON_RECTANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_RECTANGLE_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset
`define CPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after another
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cpr_pkg.sv
// Package: constants, types and helpers for the closest point on rectangle block
package cpr_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int NUM_VERTS      = 4;
    localparam int VIDX_BITS      = 2;

    localparam logic [VIDX_BITS-1:0] VERT_A = 2'd0;
    localparam logic [VIDX_BITS-1:0] VERT_B = 2'd1;
    localparam logic [VIDX_BITS-1:0] VERT_C = 2'd2;
    localparam logic [VIDX_BITS-1:0] VERT_D = 2'd3;

    // First adjacent vertex of each vertex
    function automatic logic [VIDX_BITS-1:0] first_neighbor(input logic [VIDX_BITS-1:0] v);
        logic [VIDX_BITS-1:0] r;
        begin
            case (v)
                VERT_A:  r = VERT_B;
                VERT_B:  r = VERT_A;
                VERT_C:  r = VERT_B;
                default: r = VERT_C;
            endcase
            return r;
        end
    endfunction

    // Second adjacent vertex of each vertex
    function automatic logic [VIDX_BITS-1:0] second_neighbor(input logic [VIDX_BITS-1:0] v);
        logic [VIDX_BITS-1:0] r;
        begin
            case (v)
                VERT_A:  r = VERT_D;
                VERT_B:  r = VERT_C;
                VERT_C:  r = VERT_D;
                default: r = VERT_A;
            endcase
            return r;
        end
    endfunction
endpackage

>>> hw/rtl/cpr_stream_if.sv
// Valid/ready stream interface carrying a payload
interface cpr_stream_if #(
    parameter int WIDTH = 32
) (
    input logic clk
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/cpr_edge_unit.sv
// Pipelined projection of a point onto one edge, with clamp and box check
module cpr_edge_unit #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [CB-1:0] sx,
    input  logic signed [CB-1:0] sy,
    input  logic signed [CB-1:0] ex,
    input  logic signed [CB-1:0] ey,
    input  logic signed [CB-1:0] px,
    input  logic signed [CB-1:0] py,
    output logic signed [CB-1:0] qx,
    output logic signed [CB-1:0] qy
);
    import cpr_pkg::*;

    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 3;
    localparam int NW = PW + DW;

    // Stage 1: differences, squared length and dot product
    logic signed [DW-1:0] dex, dey, dpx, dpy;
    logic signed [PW-1:0] len2_s, dot_s;
    assign dex = DW'(ex) - DW'(sx);
    assign dey = DW'(ey) - DW'(sy);
    assign dpx = DW'(px) - DW'(sx);
    assign dpy = DW'(py) - DW'(sy);
    assign len2_s = PW'(dex * dex) + PW'(dey * dey);
    assign dot_s  = PW'(dpx * dex) + PW'(dpy * dey);

    logic signed [DW-1:0] ex1_reg, ey1_reg;
    logic signed [PW-1:0] len1_reg, dot1_reg;
    logic signed [CB-1:0] s1x_reg, s1y_reg, e1x_reg, e1y_reg, p1x_reg, p1y_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex1_reg <= dex; ey1_reg <= dey;
            len1_reg <= len2_s; dot1_reg <= dot_s;
            s1x_reg <= sx; s1y_reg <= sy; e1x_reg <= ex; e1y_reg <= ey;
            p1x_reg <= px; p1y_reg <= py;
        end
    end

    // Stage 2: pick mode and form the numerators (ex-sx)*dot, (ey-sy)*dot
    logic [1:0] mode_s;
    localparam logic [1:0] M_START = 2'd0, M_END = 2'd1, M_PROJ = 2'd2;
    always_comb
    begin
        if (len1_reg == '0 || dot1_reg < 0)
            mode_s = M_START;
        else if (dot1_reg > len1_reg)
            mode_s = M_END;
        else
            mode_s = M_PROJ;
    end
    logic [1:0] mode2_reg;
    logic signed [NW-1:0] nx2_reg, ny2_reg;
    logic [PW-1:0] len2_reg;
    logic signed [CB-1:0] s2x_reg, s2y_reg, e2x_reg, e2y_reg, p2x_reg, p2y_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode2_reg <= mode_s;
            nx2_reg <= NW'(ex1_reg) * NW'(dot1_reg);
            ny2_reg <= NW'(ey1_reg) * NW'(dot1_reg);
            len2_reg <= len1_reg[PW-1:0];
            s2x_reg <= s1x_reg; s2y_reg <= s1y_reg; e2x_reg <= e1x_reg; e2y_reg <= e1y_reg;
            p2x_reg <= p1x_reg; p2y_reg <= p1y_reg;
        end
    end

    // Restoring division pipeline on magnitudes, one quotient bit a stage
    logic [NW-1:0] ax_s, ay_s;
    assign ax_s = nx2_reg[NW-1] ? NW'(-nx2_reg) : NW'(nx2_reg);
    assign ay_s = ny2_reg[NW-1] ? NW'(-ny2_reg) : NW'(ny2_reg);

    logic [NW-1:0] qxd_reg [0:NW];
    logic [NW-1:0] qyd_reg [0:NW];
    logic [PW:0]   rx_reg  [0:NW];
    logic [PW:0]   ry_reg  [0:NW];
    logic [PW-1:0] dv_reg  [0:NW];
    logic          nxs_reg [0:NW];
    logic          nys_reg [0:NW];
    logic [1:0]    md_reg  [0:NW];
    logic signed [CB-1:0] ds_x_reg [0:NW], ds_y_reg [0:NW], de_x_reg [0:NW],
                          de_y_reg [0:NW], dp_x_reg [0:NW], dp_y_reg [0:NW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qxd_reg[0] <= ax_s; qyd_reg[0] <= ay_s;
            rx_reg[0] <= '0; ry_reg[0] <= '0;
            dv_reg[0] <= (len2_reg == '0) ? PW'(1) : len2_reg;
            nxs_reg[0] <= nx2_reg[NW-1]; nys_reg[0] <= ny2_reg[NW-1];
            md_reg[0] <= mode2_reg;
            ds_x_reg[0] <= s2x_reg; ds_y_reg[0] <= s2y_reg;
            de_x_reg[0] <= e2x_reg; de_y_reg[0] <= e2y_reg;
            dp_x_reg[0] <= p2x_reg; dp_y_reg[0] <= p2y_reg;
        end
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_div
        logic [PW+1:0] tx, ty;
        logic [PW+1:0] sx_t, sy_t;
        assign tx = {rx_reg[i], qxd_reg[i][NW-1]};
        assign ty = {ry_reg[i], qyd_reg[i][NW-1]};
        assign sx_t = tx - {2'b00, dv_reg[i]};
        assign sy_t = ty - {2'b00, dv_reg[i]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[i+1] <= sx_t[PW+1] ? tx[PW:0] : sx_t[PW:0];
                ry_reg[i+1] <= sy_t[PW+1] ? ty[PW:0] : sy_t[PW:0];
                qxd_reg[i+1] <= {qxd_reg[i][NW-2:0], ~sx_t[PW+1]};
                qyd_reg[i+1] <= {qyd_reg[i][NW-2:0], ~sy_t[PW+1]};
                dv_reg[i+1] <= dv_reg[i];
                nxs_reg[i+1] <= nxs_reg[i]; nys_reg[i+1] <= nys_reg[i];
                md_reg[i+1] <= md_reg[i];
                ds_x_reg[i+1] <= ds_x_reg[i]; ds_y_reg[i+1] <= ds_y_reg[i];
                de_x_reg[i+1] <= de_x_reg[i]; de_y_reg[i+1] <= de_y_reg[i];
                dp_x_reg[i+1] <= dp_x_reg[i]; dp_y_reg[i+1] <= dp_y_reg[i];
            end
        end
    end

    // Floor quotient: negate and round down for negative numerators
    logic signed [DW+1:0] fx, fy, cx, cy;
    logic rzx, rzy;
    assign rzx = (rx_reg[NW] == '0);
    assign rzy = (ry_reg[NW] == '0);
    assign fx = nxs_reg[NW] ? -((DW+2)'(qxd_reg[NW]) + (DW+2)'(!rzx))
                            : (DW+2)'(qxd_reg[NW]);
    assign fy = nys_reg[NW] ? -((DW+2)'(qyd_reg[NW]) + (DW+2)'(!rzy))
                            : (DW+2)'(qyd_reg[NW]);
    assign cx = (DW+2)'(ds_x_reg[NW]) + fx;
    assign cy = (DW+2)'(ds_y_reg[NW]) + fy;

    // Final stage: choose point, apply box check
    logic signed [DW+1:0] tqx, tqy, lox, hix, loy, hiy;
    logic signed [PW-1:0] dsq_s, deq_s;
    logic signed [DW-1:0] a0, a1, b0, b1;
    always_comb
    begin
        case (md_reg[NW])
            M_START: begin tqx = (DW+2)'(ds_x_reg[NW]); tqy = (DW+2)'(ds_y_reg[NW]); end
            M_END:   begin tqx = (DW+2)'(de_x_reg[NW]); tqy = (DW+2)'(de_y_reg[NW]); end
            default: begin tqx = cx; tqy = cy; end
        endcase
        lox = (DW+2)'((ds_x_reg[NW] < de_x_reg[NW]) ? ds_x_reg[NW] : de_x_reg[NW]);
        hix = (DW+2)'((ds_x_reg[NW] < de_x_reg[NW]) ? de_x_reg[NW] : ds_x_reg[NW]);
        loy = (DW+2)'((ds_y_reg[NW] < de_y_reg[NW]) ? ds_y_reg[NW] : de_y_reg[NW]);
        hiy = (DW+2)'((ds_y_reg[NW] < de_y_reg[NW]) ? de_y_reg[NW] : ds_y_reg[NW]);
        a0 = DW'(dp_x_reg[NW]) - DW'(ds_x_reg[NW]);
        a1 = DW'(dp_y_reg[NW]) - DW'(ds_y_reg[NW]);
        b0 = DW'(dp_x_reg[NW]) - DW'(de_x_reg[NW]);
        b1 = DW'(dp_y_reg[NW]) - DW'(de_y_reg[NW]);
        dsq_s = PW'(a0 * a0) + PW'(a1 * a1);
        deq_s = PW'(b0 * b0) + PW'(b1 * b1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tqx < lox || tqx > hix || tqy < loy || tqy > hiy)
            begin
                qx <= (dsq_s <= deq_s) ? ds_x_reg[NW] : de_x_reg[NW];
                qy <= (dsq_s <= deq_s) ? ds_y_reg[NW] : de_y_reg[NW];
            end
            else
            begin
                qx <= tqx[CB-1:0];
                qy <= tqy[CB-1:0];
            end
        end
    end
endmodule

>>> hw/rtl/closest_point_on_rectangle.sv
// Closest point on rectangle perimeter: pipelined top level
// The pipeline depth is set mostly by the one-bit-per-stage divider in the edge units.
// Throughput: one transaction per cycle; the whole pipe advances as one when
// the output register is free or being drained, and holds while a result waits.
// Reset: valid bits clear asynchronously on rst_n low; data registers keep garbage.
`include "closest_point_on_rectangle_defines.svh"
module closest_point_on_rectangle #(
    parameter int COORD_BITS = cpr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cpr_pkg::FRAC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    cpr_stream_if.sink   in_ch,
    cpr_stream_if.source out_ch
);
    import cpr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 3;
    localparam int NW = PW + DW;
    localparam int DEPTH = NW + 7;
    localparam int FB_USE = FRAC_BITS;

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;

    // Unpack input
    logic signed [CB-1:0] vx [0:NUM_VERTS-1];
    logic signed [CB-1:0] vy [0:NUM_VERTS-1];
    logic signed [CB-1:0] qpx, qpy;
    for (genvar k = 0; k < NUM_VERTS; k++)
    begin : g_unpack
        assign vx[k] = in_ch.data[(2*k)*CB +: CB];
        assign vy[k] = in_ch.data[(2*k+1)*CB +: CB];
    end
    assign qpx = in_ch.data[8*CB +: CB];
    assign qpy = in_ch.data[9*CB +: CB];

    // Stage A: squared distances to vertices
    logic [PW-1:0] dist_reg [0:NUM_VERTS-1];
    logic signed [CB-1:0] vxa_reg [0:NUM_VERTS-1];
    logic signed [CB-1:0] vya_reg [0:NUM_VERTS-1];
    logic signed [CB-1:0] pxa_reg, pya_reg;
    for (genvar k = 0; k < NUM_VERTS; k++)
    begin : g_dist
        logic signed [DW-1:0] ddx, ddy;
        assign ddx = DW'(qpx) - DW'(vx[k]);
        assign ddy = DW'(qpy) - DW'(vy[k]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dist_reg[k] <= PW'(ddx * ddx) + PW'(ddy * ddy);
                vxa_reg[k] <= vx[k];
                vya_reg[k] <= vy[k];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxa_reg <= qpx;
            pya_reg <= qpy;
        end
    end

    // Stage B: nearest vertex and the edges from it to its neighbours
    logic [VIDX_BITS-1:0] near_s, n1_s, n2_s;
    logic [PW-1:0] best_s;
    always_comb
    begin
        near_s = VERT_A;
        best_s = dist_reg[0];
        for (int k = 1; k < NUM_VERTS; k++)
        begin
            if (dist_reg[k] < best_s)
            begin
                best_s = dist_reg[k];
                near_s = VIDX_BITS'(k);
            end
        end
        n1_s = first_neighbor(near_s);
        n2_s = second_neighbor(near_s);
    end
    logic signed [CB-1:0] sbx_reg, sby_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [CB-1:0] pxb_reg, pyb_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbx_reg <= vxa_reg[near_s]; sby_reg <= vya_reg[near_s];
            e1x_reg <= vxa_reg[n1_s];   e1y_reg <= vya_reg[n1_s];
            e2x_reg <= vxa_reg[n2_s];   e2y_reg <= vya_reg[n2_s];
            pxb_reg <= pxa_reg; pyb_reg <= pya_reg;
        end
    end

    // Edge projections
    logic signed [CB-1:0] q1x, q1y, q2x, q2y;
    cpr_edge_unit #(.CB(CB)) u_edge1 (
        .clk(clk), .adv(adv), .sx(sbx_reg), .sy(sby_reg), .ex(e1x_reg), .ey(e1y_reg),
        .px(pxb_reg), .py(pyb_reg), .qx(q1x), .qy(q1y)
    );
    cpr_edge_unit #(.CB(CB)) u_edge2 (
        .clk(clk), .adv(adv), .sx(sbx_reg), .sy(sby_reg), .ex(e2x_reg), .ey(e2y_reg),
        .px(pxb_reg), .py(pyb_reg), .qx(q2x), .qy(q2y)
    );

    // Delay query point to match the edge units
    logic signed [CB-1:0] pdx_reg [0:NW+3];
    logic signed [CB-1:0] pdy_reg [0:NW+3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdx_reg[0] <= pxb_reg;
            pdy_reg[0] <= pyb_reg;
            for (int i = 1; i <= NW + 3; i++)
            begin
                pdx_reg[i] <= pdx_reg[i-1];
                pdy_reg[i] <= pdy_reg[i-1];
            end
        end
    end

    // Final pick: nearer of the edge points from both edge units, first edge on a tie
    logic signed [DW-1:0] g0, g1, h0, h1;
    logic [PW-1:0] d1_s, d2_s;
    assign g0 = DW'(pdx_reg[NW+3]) - DW'(q1x);
    assign g1 = DW'(pdy_reg[NW+3]) - DW'(q1y);
    assign h0 = DW'(pdx_reg[NW+3]) - DW'(q2x);
    assign h1 = DW'(pdy_reg[NW+3]) - DW'(q2y);
    assign d1_s = PW'(g0 * g0) + PW'(g1 * g1);
    assign d2_s = PW'(h0 * h0) + PW'(h1 * h1);

    logic signed [CB-1:0] rx_reg, ry_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg <= (d1_s <= d2_s) ? q1x : q2x;
            ry_reg <= (d1_s <= d2_s) ? q1y : q2y;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    assign out_ch.valid = vld_reg[DEPTH-1] && (FB_USE >= 0);
    assign out_ch.data  = {ry_reg, rx_reg};

    `CPR_ASSERT_IMPL(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        !in_ch.ready, "input taken while output stalled")
    `CPR_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.data), "stalled result lost")
    `CPR_ASSERT_NEXT(a_enter, clk, rst_n, in_ch.valid && in_ch.ready,
        vld_reg[0], "accepted transaction not tracked")
endmodule

>>> dv/closest_point_on_rectangle_tb.sv
// Testbench for the closest point on rectangle block: directed and random stimulus, scoreboard check
module closest_point_on_rectangle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = cpr_pkg::COORD_BITS_DEF;

    // Query transaction, vertex_a_x in the low bits
    typedef struct packed {
        logic signed [CB-1:0] query_y;
        logic signed [CB-1:0] query_x;
        logic signed [CB-1:0] vertex_d_y;
        logic signed [CB-1:0] vertex_d_x;
        logic signed [CB-1:0] vertex_c_y;
        logic signed [CB-1:0] vertex_c_x;
        logic signed [CB-1:0] vertex_b_y;
        logic signed [CB-1:0] vertex_b_x;
        logic signed [CB-1:0] vertex_a_y;
        logic signed [CB-1:0] vertex_a_x;
    } query_t;

    typedef struct packed {
        logic signed [CB-1:0] nearest_y;
        logic signed [CB-1:0] nearest_x;
    } nearest_t;

    logic clk;
    logic rst_n;

    cpr_stream_if #(.WIDTH($bits(query_t)))   in_ch (clk);
    cpr_stream_if #(.WIDTH($bits(nearest_t))) out_ch (clk);

    closest_point_on_rectangle i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    query_t   pending_queries[$];
    nearest_t expected_points[$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic longint dist2(input longint ax, input longint ay,
                                     input longint bx, input longint by);
        return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
    endfunction

    // Quotient rounded toward minus infinity, den > 0
    function automatic longint div_floor(input longint num, input longint den);
        if (num >= 0)
            return num / den;
        return -(((-num) + den - 1) / den);
    endfunction

    // Nearest point of edge S-E to P, clamped to the edge
    function automatic void project_edge(input longint sx, input longint sy,
                                         input longint ex, input longint ey,
                                         input longint px, input longint py,
                                         output longint qx, output longint qy);
        longint dx, dy, len2, dp;
        dx = ex - sx;
        dy = ey - sy;
        len2 = dx * dx + dy * dy;
        dp = (len2 > 0) ? ((px - sx) * dx + (py - sy) * dy) : 0;
        if (dp < 0 || len2 == 0)
        begin
            qx = sx;
            qy = sy;
        end
        else if (dp > len2)
        begin
            qx = ex;
            qy = ey;
        end
        else
        begin
            qx = sx + div_floor(dx * dp, len2);
            qy = sy + div_floor(dy * dp, len2);
        end
        // Fall back to the nearer endpoint outside the bounding box
        if (qx < ((sx < ex) ? sx : ex) || qx > ((sx < ex) ? ex : sx) ||
            qy < ((sy < ey) ? sy : ey) || qy > ((sy < ey) ? ey : sy))
        begin
            if (dist2(px, py, sx, sy) <= dist2(px, py, ex, ey))
            begin
                qx = sx;
                qy = sy;
            end
            else
            begin
                qx = ex;
                qy = ey;
            end
        end
    endfunction

    function automatic nearest_t predict_nearest(input query_t q);
        longint vx[4], vy[4], px, py, best, dk, ax, ay, bx, by;
        int near_idx, n1, n2;
        nearest_t r;
        vx[0] = q.vertex_a_x; vy[0] = q.vertex_a_y;
        vx[1] = q.vertex_b_x; vy[1] = q.vertex_b_y;
        vx[2] = q.vertex_c_x; vy[2] = q.vertex_c_y;
        vx[3] = q.vertex_d_x; vy[3] = q.vertex_d_y;
        px = q.query_x;
        py = q.query_y;
        // Pick the nearest vertex, lowest index on a tie
        near_idx = 0;
        best = dist2(px, py, vx[0], vy[0]);
        for (int k = 1; k < 4; k++)
        begin
            dk = dist2(px, py, vx[k], vy[k]);
            if (dk < best)
            begin
                best = dk;
                near_idx = k;
            end
        end
        case (near_idx)
            cpr_pkg::VERT_A: begin n1 = cpr_pkg::VERT_B; n2 = cpr_pkg::VERT_D; end
            cpr_pkg::VERT_B: begin n1 = cpr_pkg::VERT_A; n2 = cpr_pkg::VERT_C; end
            cpr_pkg::VERT_C: begin n1 = cpr_pkg::VERT_B; n2 = cpr_pkg::VERT_D; end
            default:         begin n1 = cpr_pkg::VERT_C; n2 = cpr_pkg::VERT_A; end
        endcase
        project_edge(vx[near_idx], vy[near_idx], vx[n1], vy[n1], px, py, ax, ay);
        project_edge(vx[near_idx], vy[near_idx], vx[n2], vy[n2], px, py, bx, by);
        if (dist2(px, py, ax, ay) <= dist2(px, py, bx, by))
        begin
            r.nearest_x = ax[CB-1:0];
            r.nearest_y = ay[CB-1:0];
        end
        else
        begin
            r.nearest_x = bx[CB-1:0];
            r.nearest_y = by[CB-1:0];
        end
        return r;
    endfunction

    function automatic query_t make_query(input int ax, input int ay, input int bx, input int by,
                                          input int cx, input int cy, input int dx, input int dy,
                                          input int px, input int py);
        query_t q;
        q.vertex_a_x = ax[CB-1:0]; q.vertex_a_y = ay[CB-1:0];
        q.vertex_b_x = bx[CB-1:0]; q.vertex_b_y = by[CB-1:0];
        q.vertex_c_x = cx[CB-1:0]; q.vertex_c_y = cy[CB-1:0];
        q.vertex_d_x = dx[CB-1:0]; q.vertex_d_y = dy[CB-1:0];
        q.query_x = px[CB-1:0];    q.query_y = py[CB-1:0];
        return q;
    endfunction

    // Mostly true rectangles with a nearby query point, some arbitrary quads
    function automatic query_t random_query();
        int ax, ay, ux, uy, m, wx, wy, span, sel;
        query_t q;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            q = {$urandom, $urandom, $urandom, $urandom, $urandom};
            return q;
        end
        span = ($urandom_range(9) == 0) ? 32767 : (1 << $urandom_range(12, 4));
        ax = $urandom_range(2 * span) - span;
        ay = $urandom_range(2 * span) - span;
        ux = $urandom_range(2 * span) - span;
        uy = ($urandom_range(2) == 0) ? 0 : $urandom_range(2 * span) - span;
        m = $urandom_range(3);
        wx = -uy * m / 2 + (($urandom_range(3) == 0) ? ux : 0);
        wy = ux * m / 2;
        if (sel < 30)
            ax = ($urandom_range(1) != 0) ? 32767 - $urandom_range(span) : -32768 + $urandom_range(span);
        q = make_query(ax, ay, ax + ux, ay + uy, ax + ux + wx, ay + uy + wy, ax + wx, ay + wy,
                       ax + $urandom_range(4 * span) - 2 * span + ux / 2,
                       ay + $urandom_range(4 * span) - 2 * span + wy / 2);
        return q;
    endfunction

    // Drive queries and random output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.data <= pending_queries.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted query, check each accepted result
    always @(posedge clk)
    begin
        nearest_t got, want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_points.push_back(predict_nearest(query_t'(in_ch.data)));
            if (out_ch.valid && out_ch.ready)
            begin
                got = nearest_t'(out_ch.data);
                if (expected_points.size() == 0)
                    report($sformatf("unexpected result x=%0d y=%0d", got.nearest_x, got.nearest_y));
                else
                begin
                    want = expected_points.pop_front();
                    if (got.nearest_x !== want.nearest_x)
                        report($sformatf("nearest_x got %0d want %0d", got.nearest_x, want.nearest_x));
                    if (got.nearest_y !== want.nearest_y)
                        report($sformatf("nearest_y got %0d want %0d", got.nearest_y, want.nearest_y));
                end
            end
        end
    end

    // Stimulus in phases of input idling and output stalls
    initial
    begin
        int send_pcts[5] = '{0, 87, 0, 27, 0};
        int stall_pcts[5] = '{0, 0, 87, 27, 0};
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, ties, degenerate and clamped cases
        pending_queries.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                             -32768, -32768, 32767, 32767));
        pending_queries.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                                             32767, 32767, -32768, -32768));
        pending_queries.push_back(make_query(-32768, -32768, 32767, -32768, 32767, 32767,
                                             -32768, 32767, 0, 0));
        pending_queries.push_back(make_query(-32768, -32768, 32767, -32768, 32767, 32767,
                                             -32768, 32767, 32767, -32768));
        pending_queries.push_back(make_query(-32768, 32767, 32767, -32768, -32768, 32767,
                                             32767, -32768, 100, -200));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, 0, 0));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, 50, 25));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 100, 0, 100, 50, 50));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, -40, -30));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, 130, 20));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, 60, 70));
        pending_queries.push_back(make_query(0, 0, 100, 0, 100, 50, 0, 50, 90, 48));
        pending_queries.push_back(make_query(0, 0, 0, 0, 100, 50, 100, 50, 10, 3));
        pending_queries.push_back(make_query(5, 5, 5, 5, 5, 5, 5, 5, -7, 12));
        pending_queries.push_back(make_query(0, 0, 30, 40, -10, 70, -40, 30, 33, 7));
        pending_queries.push_back(make_query(0, 0, 30, 40, -10, 70, -40, 30, -15, 55));
        pending_queries.push_back(make_query(0, 0, 7, 3, 4, 10, -3, 7, 2, 5));
        pending_queries.push_back(make_query(10, 0, 0, 10, -10, 0, 0, -10, 0, 0));
        pending_queries.push_back(make_query(-20, -20, 20, -20, 20, 20, -20, 20, 20, 20));
        pending_queries.push_back(make_query(3, -9, 250, 17, -1000, 4000, 8, 8, 77, -300));

        for (int ph = 0; ph < 5; ph++)
        begin
            send_idle_pct = send_pcts[ph];
            stall_pct = stall_pcts[ph];
            for (int n = 0; n < 366; n++)
                pending_queries.push_back(random_query());
            while (pending_queries.size() > 0 || expected_points.size() > 0)
                @(posedge clk);
        end

        // Drain: catch any stray result
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
